>>> src/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is active.
`define MLPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define MLPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MLPT_ASSERT(lbl, clk, rst_n, prop, msg)

`define MLPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> src/mlpt_pkg.sv
// Types, widths and command codes for the LED pulse-train generator.
package mlpt_pkg;

  localparam int NUM_LEDS_DEF    = 4;
  localparam int PERIOD_BITS_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 2;
  localparam int PER_W   = 16;
  localparam int CNT_W   = 8;
  localparam int EDGE_W  = 9;
  localparam int MASK_W  = 4;
  localparam int CFG_W   = 3;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PER_W-1:0]  period_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [EDGE_W-1:0] edges_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  localparam func_t FN_TICK   = 3'd0;
  localparam func_t FN_ON     = 3'd1;
  localparam func_t FN_OFF    = 3'd2;
  localparam func_t FN_TOGGLE = 3'd3;
  localparam func_t FN_START  = 3'd4;
  localparam func_t FN_STOP   = 3'd5;

endpackage

>>> src/mlpt_if.sv
// Valid/ready channel interfaces for command items and result items.
interface mlpt_in_if;
  logic                 valid;
  logic                 ready;
  mlpt_pkg::func_t      func;
  mlpt_pkg::idx_t       led_index;
  mlpt_pkg::period_t    pulse_period;
  mlpt_pkg::count_t     pulse_count;

  modport source (output valid, func, led_index, pulse_period, pulse_count, input ready);
  modport sink   (input valid, func, led_index, pulse_period, pulse_count, output ready);
endinterface

interface mlpt_out_if;
  logic                 valid;
  logic                 ready;
  mlpt_pkg::mask_t      led_levels;
  mlpt_pkg::mask_t      trains_running;

  modport source (output valid, led_levels, trains_running, input ready);
  modport sink   (input valid, led_levels, trains_running, output ready);
endinterface

>>> src/multi_led_pulse_train_generator.sv
// Top level of the multi-channel LED pulse-train generator.
//
//   port    dir  handshake     contents
//   in_ch   in   valid/ready   func, led_index, pulse_period, pulse_count
//   out_ch  out  valid/ready   led_levels, trains_running
//   cfg_*   in   write enable  leds_in_use
//
// One item per cycle sustained while out_ch.ready stays high; a result is offered once its item
// has passed the input register, then the channel update into the result register.
// All channel timers update in parallel in the cycle an item leaves the input register.
// rst_n clears the channel state, both registers' valid flags and sets leds_in_use to 1.
// A result not taken holds the result register; the input register takes one more item,
// then in_ch.ready drops until the result leaves.
module multi_led_pulse_train_generator #(
  parameter int NUM_LEDS    = mlpt_pkg::NUM_LEDS_DEF,
  parameter int PERIOD_BITS = mlpt_pkg::PERIOD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  mlpt_pkg::cfg_t     cfg_wdata,
  mlpt_in_if.sink            in_ch,
  mlpt_out_if.source         out_ch
);
  import mlpt_pkg::*;

  localparam logic [31:0] HALF_MAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

  cfg_t                    cfg_r;

  logic                    s1_valid_r, s1_valid_nxt;
  func_t                   s1_func_r;
  idx_t                    s1_idx_r;
  period_t                 s1_period_r;
  count_t                  s1_count_r;

  logic                    out_valid_r, out_valid_nxt;
  mask_t                   levels_r, levels_nxt;
  mask_t                   running_r, running_nxt;

  logic [NUM_LEDS-1:0]     level_r, level_nxt;
  logic [NUM_LEDS-1:0]     active_r, active_nxt;
  logic [PERIOD_BITS-1:0]  half_r  [NUM_LEDS];
  logic [PERIOD_BITS-1:0]  half_nxt[NUM_LEDS];
  logic [PERIOD_BITS-1:0]  tte_r   [NUM_LEDS];
  logic [PERIOD_BITS-1:0]  tte_nxt [NUM_LEDS];
  edges_t                  edges_r [NUM_LEDS];
  edges_t                  edges_nxt[NUM_LEDS];

  logic                    s2_free, s1_fire, in_fire;
  logic                    idx_ok;
  logic [NUM_LEDS-1:0]     sel;
  period_t                 half_raw;
  logic [31:0]             half_wide;
  logic [PERIOD_BITS-1:0]  half_load;
  edges_t                  edges_load;
  logic                    chk_idle_bad, chk_run_bad;

  assign s2_free     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // half period: floor of half, at least one, clipped to the timer width
  assign half_raw   = (s1_period_r[PER_W-1:1] == '0) ? PER_W'(1)
                                                     : {1'b0, s1_period_r[PER_W-1:1]};
  assign half_wide  = (32'(half_raw) > HALF_MAX) ? HALF_MAX : 32'(half_raw);
  assign half_load  = half_wide[PERIOD_BITS-1:0];
  assign edges_load = {s1_count_r, 1'b0};

  assign idx_ok = (CFG_W'(s1_idx_r) < cfg_r);

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      sel[i] = idx_ok && (32'(s1_idx_r) == i);
    end
  end

  always_comb begin
    level_nxt  = level_r;
    active_nxt = active_r;
    half_nxt   = half_r;
    tte_nxt    = tte_r;
    edges_nxt  = edges_r;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (s1_func_r == FN_TICK) begin
        if (active_r[i]) begin
          if (tte_r[i] > PERIOD_BITS'(1)) begin
            tte_nxt[i] = tte_r[i] - PERIOD_BITS'(1);
          end else if (edges_r[i] <= EDGE_W'(1)) begin
            level_nxt[i]  = 1'b0;
            active_nxt[i] = 1'b0;
            tte_nxt[i]    = '0;
            edges_nxt[i]  = '0;
          end else begin
            tte_nxt[i]   = half_r[i];
            edges_nxt[i] = edges_r[i] - EDGE_W'(1);
            level_nxt[i] = !level_r[i];
          end
        end
      end else if (sel[i]) begin
        case (s1_func_r)
          FN_ON, FN_OFF, FN_STOP, FN_TOGGLE: begin
            active_nxt[i] = 1'b0;
            tte_nxt[i]    = '0;
            edges_nxt[i]  = '0;
            level_nxt[i]  = (s1_func_r == FN_ON) ||
                            ((s1_func_r == FN_TOGGLE) && !level_r[i]);
          end
          FN_START: begin
            level_nxt[i]  = 1'b1;
            active_nxt[i] = 1'b0;
            tte_nxt[i]    = '0;
            edges_nxt[i]  = '0;
            if (s1_count_r != '0) begin
              active_nxt[i] = 1'b1;
              half_nxt[i]   = half_load;
              tte_nxt[i]    = half_load;
              edges_nxt[i]  = edges_load;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_LEDS) begin : g_led
      assign levels_nxt[b]  = level_nxt[b];
      assign running_nxt[b] = active_nxt[b];
    end else begin : g_none
      assign levels_nxt[b]  = 1'b0;
      assign running_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(1);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      active_r    <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        half_r[i]  <= '0;
        tte_r[i]   <= '0;
        edges_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        level_r  <= level_nxt;
        active_r <= active_nxt;
        half_r   <= half_nxt;
        tte_r    <= tte_nxt;
        edges_r  <= edges_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r   <= in_ch.func;
      s1_idx_r    <= in_ch.led_index;
      s1_period_r <= in_ch.pulse_period;
      s1_count_r  <= in_ch.pulse_count;
    end
    if (s1_fire) begin
      levels_r  <= levels_nxt;
      running_r <= running_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_levels     = levels_r;
  assign out_ch.trains_running = running_r;

  always_comb begin
    chk_idle_bad = 1'b0;
    chk_run_bad  = 1'b0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (!active_r[i] && (tte_r[i] != '0 || edges_r[i] != '0)) chk_idle_bad = 1'b1;
      if (active_r[i] && (tte_r[i] == '0 || tte_r[i] > half_r[i] || edges_r[i] == '0))
        chk_run_bad = 1'b1;
    end
  end

`include "assert_macros.svh"

  `MLPT_ASSERT(a_idle_clear, clk, rst_n, !chk_idle_bad, "stopped channel keeps timer state")
  `MLPT_ASSERT(a_run_sane, clk, rst_n, !chk_run_bad, "running channel has bad timer state")
  `MLPT_ASSERT(a_stall_src, clk, rst_n, !in_ch.ready |-> (s1_valid_r && out_valid_r), "stall without full stages")
  `MLPT_ASSERT(a_result_follows, clk, rst_n, s1_fire |=> out_valid_r, "update without result")
  `MLPT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !s1_valid_r), "stages not empty after reset")

endmodule
